[rtl/lpht_pkg.sv]
// Shared action codes, status codes and the hash multiplier for the linear probe hash table.
package lpht_pkg;

    localparam int ACTION_W = 3;
    localparam int STATUS_W = 2;

    typedef logic [ACTION_W-1:0] action_t;
    typedef logic [STATUS_W-1:0] status_t;

    localparam action_t ACT_GET   = 3'd0;
    localparam action_t ACT_SET   = 3'd1;
    localparam action_t ACT_POP   = 3'd2;
    localparam action_t ACT_INDEX = 3'd3;
    localparam action_t ACT_CLEAR = 3'd4;

    localparam status_t ST_OK        = 2'd0;
    localparam status_t ST_NOT_FOUND = 2'd1;
    localparam status_t ST_FULL      = 2'd2;
    localparam status_t ST_RANGE     = 2'd3;

    // Odd multiplier for the start-slot mixing step.
    localparam logic [31:0] HASH_MULT = 32'h9E37_79B1;

endpackage

[rtl/lpht_ram.sv]
// Generic single-write, single-read RAM with a registered read port.
module lpht_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

[rtl/lpht_hash.sv]
// Two-stage seeded hash that maps a key and its type tag to a start slot.
module lpht_hash #(
    parameter int SLOTS        = 1024,
    parameter int PAYLOAD_BITS = 64,
    parameter int TYPE_BITS    = 4
) (
    input  logic                     aclk,
    input  logic [PAYLOAD_BITS-1:0]  key,
    input  logic [TYPE_BITS-1:0]     key_type,
    input  logic [31:0]              seed,
    output logic [$clog2(SLOTS)-1:0] start
);

    localparam int SW = $clog2(SLOTS);

    logic [63:0] key_ext;
    logic [31:0] fold;
    logic [63:0] prod;
    logic [32:0] scaled;
    logic [31:0] s1_reg;
    logic [31:0] s2_reg;

    assign key_ext = 64'(key);
    assign fold    = key_ext[63:32] ^ key_ext[31:0] ^ (32'(key_type) << 24) ^ seed;
    assign prod    = 64'(s1_reg) * 64'(lpht_pkg::HASH_MULT);

    always_ff @(posedge aclk) begin
        s1_reg <= fold;
        s2_reg <= prod[47:16];
    end

    // Multiply-shift range reduction keeps the start slot below SLOTS.
    assign scaled = 33'(s2_reg[31:16]) * 33'(SLOTS);
    assign start  = scaled[16 +: SW];

endmodule

[rtl/linear_probe_hash_table_unit.sv]
// Top level of the linear probe hash table: sequencer around the slot and entry memories.
//
// Usage: items enter on the s_ channel (valid/ready) and one result per item leaves on
// the m_ channel (valid/ready). The hash seed is written through cfg_wr_en/cfg_wr_data;
// the user must do so only while the block is idle, which the block does not enforce.
// A get or set walks the slots from its start slot, one slot per cycle through the slot
// memory read port. A pop adds the forward and backward tombstone scans (one slot per
// cycle each) and moves the last entry into the hole. Clear sweeps the slot memory.
// The block works on one item at a time; s_ready is high only when it is idle.
// A finished result sits in an output register, so the next item is taken while the
// previous result waits; the block holds a new result until that register frees up.
// Reset: aresetn is synchronous and active low. After reset a clearing pass writes
// every slot empty; s_ready stays low during it, and seed writes are still taken. The
// entry memory is not cleared.
module linear_probe_hash_table_unit #(
    parameter int SLOTS        = 1024,
    parameter int MAX_ENTRIES  = 768,
    parameter int PAYLOAD_BITS = 64,
    parameter int TYPE_BITS    = 4
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic                                 cfg_wr_en,
    input  logic [31:0]                          cfg_wr_data,
    input  logic                                 s_valid,
    output logic                                 s_ready,
    input  lpht_pkg::action_t                    s_action,
    input  logic [PAYLOAD_BITS-1:0]              s_key,
    input  logic [TYPE_BITS-1:0]                 s_key_type,
    input  logic [PAYLOAD_BITS-1:0]              s_value,
    input  logic [TYPE_BITS-1:0]                 s_value_type,
    input  logic [$clog2(MAX_ENTRIES+1)-1:0]     s_position,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output lpht_pkg::status_t                    m_status,
    output logic [PAYLOAD_BITS-1:0]              m_out_key,
    output logic [TYPE_BITS-1:0]                 m_out_key_type,
    output logic [PAYLOAD_BITS-1:0]              m_out_value,
    output logic [TYPE_BITS-1:0]                 m_out_value_type,
    output logic [$clog2(MAX_ENTRIES+1)-1:0]     m_entry_count
);

    localparam int SW  = $clog2(SLOTS);
    localparam int EAW = $clog2(MAX_ENTRIES);
    localparam int CW  = $clog2(MAX_ENTRIES+1);
    localparam int PB  = PAYLOAD_BITS;
    localparam int TB  = TYPE_BITS;
    localparam int SWD = TB + PB + EAW;
    localparam int EWD = SW + TB + PB;

    localparam logic [SW-1:0] SLOT_LAST = SW'(SLOTS - 1);
    localparam logic [SW:0]   SLOT_LIM  = (SW+1)'(SLOTS);
    localparam logic [CW-1:0] ENT_MAX   = CW'(MAX_ENTRIES);

    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_DECODE = 5'd1;
    localparam logic [4:0] S_HASH   = 5'd2;
    localparam logic [4:0] S_PSTART = 5'd3;
    localparam logic [4:0] S_PROBE  = 5'd4;
    localparam logic [4:0] S_ENT    = 5'd5;
    localparam logic [4:0] S_POPV   = 5'd6;
    localparam logic [4:0] S_FWD    = 5'd7;
    localparam logic [4:0] S_BWD    = 5'd8;
    localparam logic [4:0] S_MOVE0  = 5'd9;
    localparam logic [4:0] S_MOVE_E = 5'd10;
    localparam logic [4:0] S_MOVE_S = 5'd11;
    localparam logic [4:0] S_IDX_E  = 5'd12;
    localparam logic [4:0] S_IDX_S  = 5'd13;
    localparam logic [4:0] S_INIT   = 5'd14;
    localparam logic [4:0] S_CLR    = 5'd15;
    localparam logic [4:0] S_FINISH = 5'd16;

    // Control state.
    logic [4:0]    state_reg, state_next;
    logic [SW-1:0] cur_reg, cur_next;
    logic [SW-1:0] n_reg, n_next;
    logic [SW-1:0] tomb_reg, tomb_next;
    logic          have_tomb_reg, have_tomb_next;
    logic [CW-1:0] count_reg, count_next;
    logic [31:0]   seed_reg, seed_next;
    logic          m_valid_reg, m_valid_next;

    // Item and result payload.
    logic [EAW-1:0]          ent_reg, ent_next;
    lpht_pkg::action_t       act_reg;
    logic [PB-1:0]           key_reg;
    logic [TB-1:0]           ktag_reg;
    logic [PB-1:0]           val_reg;
    logic [TB-1:0]           vtag_reg;
    logic [CW-1:0]           pos_reg;
    lpht_pkg::status_t       rstat_reg, rstat_next;
    logic [PB-1:0]           rkey_reg, rkey_next;
    logic [TB-1:0]           rktag_reg, rktag_next;
    logic [PB-1:0]           rval_reg, rval_next;
    logic [TB-1:0]           rvtag_reg, rvtag_next;
    lpht_pkg::status_t       ostat_reg;
    logic [PB-1:0]           okey_reg;
    logic [TB-1:0]           oktag_reg;
    logic [PB-1:0]           oval_reg;
    logic [TB-1:0]           ovtag_reg;
    logic [CW-1:0]           ocount_reg;

    // Memory ports.
    logic           sm_we;
    logic [SW-1:0]  sm_waddr, sm_raddr;
    logic [SWD-1:0] sm_wdata, sm_rdata;
    logic           em_we;
    logic [EAW-1:0] em_waddr, em_raddr;
    logic [EWD-1:0] em_wdata, em_rdata;

    logic [SW-1:0]  hash_start;
    logic           accept;
    logic           load_out;

    // Decoded memory words.
    logic [TB-1:0]  sr_tag;
    logic [PB-1:0]  sr_pay;
    logic [EAW-1:0] sr_ent;
    logic [SW-1:0]  er_slot;
    logic [SW-1:0]  er_slot_ok;
    logic [TB-1:0]  er_vtag;
    logic [PB-1:0]  er_val;

    logic           sr_match, sr_empty, sr_tomb, n_last;
    logic [SW-1:0]  cur_nxt, cur_prv;
    logic [EAW-1:0] ent_clamp;
    logic [CW-1:0]  count_m1;

    assign sr_tag = sm_rdata[SWD-1 -: TB];
    assign sr_pay = sm_rdata[EAW +: PB];
    assign sr_ent = sm_rdata[EAW-1:0];

    assign er_slot = em_rdata[EWD-1 -: SW];
    assign er_vtag = em_rdata[PB +: TB];
    assign er_val  = em_rdata[PB-1:0];

    // A stale entry may point past the slot array when SLOTS is not a power of two.
    assign er_slot_ok = ({1'b0, er_slot} >= SLOT_LIM) ? '0 : er_slot;

    assign sr_match = (sr_tag == ktag_reg) && (sr_pay == key_reg);
    assign sr_empty = (sr_tag == '0) && (sr_pay == '0);
    assign sr_tomb  = (sr_tag == '0) && (sr_pay != '0);
    assign n_last   = (n_reg == SLOT_LAST);
    assign cur_nxt  = (cur_reg == SLOT_LAST) ? '0 : cur_reg + SW'(1);
    assign cur_prv  = (cur_reg == '0) ? SLOT_LAST : cur_reg - SW'(1);
    assign count_m1 = count_reg - CW'(1);
    assign ent_clamp = (CW'(sr_ent) >= count_reg) ? count_m1[EAW-1:0] : sr_ent;

    assign s_ready  = (state_reg == S_IDLE);
    assign accept   = s_valid && s_ready;
    assign load_out = (state_reg == S_FINISH) && (!m_valid_reg || m_ready);

    lpht_hash #(
        .SLOTS        (SLOTS),
        .PAYLOAD_BITS (PAYLOAD_BITS),
        .TYPE_BITS    (TYPE_BITS)
    ) u_hash (
        .aclk     (aclk),
        .key      (key_reg),
        .key_type (ktag_reg),
        .seed     (seed_reg),
        .start    (hash_start)
    );

    lpht_ram #(
        .WIDTH (SWD),
        .DEPTH (SLOTS)
    ) u_slot_ram (
        .aclk  (aclk),
        .we    (sm_we),
        .waddr (sm_waddr),
        .wdata (sm_wdata),
        .raddr (sm_raddr),
        .rdata (sm_rdata)
    );

    lpht_ram #(
        .WIDTH (EWD),
        .DEPTH (MAX_ENTRIES)
    ) u_entry_ram (
        .aclk  (aclk),
        .we    (em_we),
        .waddr (em_waddr),
        .wdata (em_wdata),
        .raddr (em_raddr),
        .rdata (em_rdata)
    );

    always_comb begin
        state_next     = state_reg;
        cur_next       = cur_reg;
        n_next         = n_reg;
        tomb_next      = tomb_reg;
        have_tomb_next = have_tomb_reg;
        count_next     = count_reg;
        ent_next       = ent_reg;
        rstat_next     = rstat_reg;
        rkey_next      = rkey_reg;
        rktag_next     = rktag_reg;
        rval_next      = rval_reg;
        rvtag_next     = rvtag_reg;
        seed_next      = cfg_wr_en ? cfg_wr_data : seed_reg;

        sm_we    = 1'b0;
        sm_waddr = cur_reg;
        sm_wdata = '0;
        sm_raddr = cur_reg;
        em_we    = 1'b0;
        em_waddr = ent_reg;
        em_wdata = '0;
        em_raddr = ent_reg;

        unique case (state_reg) inside
            S_IDLE: begin
                if (accept) begin
                    state_next = S_DECODE;
                end
            end
            S_DECODE: begin
                rstat_next = lpht_pkg::ST_OK;
                rkey_next  = key_reg;
                rktag_next = ktag_reg;
                rval_next  = '0;
                rvtag_next = '0;
                if ((act_reg == lpht_pkg::ACT_GET || act_reg == lpht_pkg::ACT_SET ||
                     act_reg == lpht_pkg::ACT_POP) && ktag_reg == '0) begin
                    rstat_next = lpht_pkg::ST_NOT_FOUND;
                    state_next = S_FINISH;
                end else begin
                    case (act_reg) inside
                        lpht_pkg::ACT_GET, lpht_pkg::ACT_SET: begin
                            state_next = S_HASH;
                        end
                        lpht_pkg::ACT_POP: begin
                            if (count_reg == '0) begin
                                rstat_next = lpht_pkg::ST_NOT_FOUND;
                                state_next = S_FINISH;
                            end else begin
                                state_next = S_HASH;
                            end
                        end
                        lpht_pkg::ACT_INDEX: begin
                            if (pos_reg >= count_reg) begin
                                rstat_next = lpht_pkg::ST_RANGE;
                                state_next = S_FINISH;
                            end else begin
                                em_raddr   = pos_reg[EAW-1:0];
                                state_next = S_IDX_E;
                            end
                        end
                        lpht_pkg::ACT_CLEAR: begin
                            cur_next   = '0;
                            state_next = S_CLR;
                        end
                        default: begin
                            state_next = S_FINISH;
                        end
                    endcase
                end
            end
            S_HASH: begin
                state_next = S_PSTART;
            end
            S_PSTART: begin
                sm_raddr       = hash_start;
                cur_next       = hash_start;
                n_next         = '0;
                have_tomb_next = 1'b0;
                state_next     = S_PROBE;
            end
            S_PROBE: begin
                if (sr_match) begin
                    if (act_reg == lpht_pkg::ACT_POP) begin
                        // Leave a tombstone and fetch the value being removed.
                        sm_we      = 1'b1;
                        sm_wdata   = {{TB{1'b0}}, PB'(1), sr_ent};
                        em_raddr   = ent_clamp;
                        ent_next   = ent_clamp;
                        state_next = S_POPV;
                    end else begin
                        em_raddr   = sr_ent;
                        ent_next   = sr_ent;
                        state_next = S_ENT;
                    end
                end else if (sr_empty || n_last) begin
                    // Key is absent; pick the first tombstone, else the ending empty slot.
                    state_next = S_FINISH;
                    if (act_reg != lpht_pkg::ACT_SET) begin
                        rstat_next = lpht_pkg::ST_NOT_FOUND;
                    end else if ((!sr_empty && !have_tomb_reg && !sr_tomb) ||
                                 count_reg >= ENT_MAX) begin
                        rstat_next = lpht_pkg::ST_FULL;
                    end else begin
                        sm_we    = 1'b1;
                        sm_waddr = (have_tomb_reg || !sr_empty) && have_tomb_reg ?
                                   tomb_reg : cur_reg;
                        sm_wdata = {ktag_reg, key_reg, count_reg[EAW-1:0]};
                        em_we    = 1'b1;
                        em_waddr = count_reg[EAW-1:0];
                        em_wdata = {sm_waddr, vtag_reg, val_reg};
                        count_next = count_reg + CW'(1);
                    end
                end else begin
                    if (sr_tomb && !have_tomb_reg) begin
                        have_tomb_next = 1'b1;
                        tomb_next      = cur_reg;
                    end
                    sm_raddr = cur_nxt;
                    cur_next = cur_nxt;
                    n_next   = n_reg + SW'(1);
                end
            end
            S_ENT: begin
                rval_next  = er_val;
                rvtag_next = er_vtag;
                if (act_reg == lpht_pkg::ACT_SET) begin
                    em_we    = 1'b1;
                    em_wdata = {cur_reg, vtag_reg, val_reg};
                end
                state_next = S_FINISH;
            end
            S_POPV: begin
                rval_next  = er_val;
                rvtag_next = er_vtag;
                sm_raddr   = cur_nxt;
                cur_next   = cur_nxt;
                n_next     = '0;
                state_next = S_FWD;
            end
            S_FWD: begin
                if (sr_tag != '0) begin
                    state_next = S_MOVE0;
                end else if (sr_pay == '0) begin
                    // Run of tombstones ends in an empty slot: walk back and clear it.
                    sm_raddr   = cur_prv;
                    cur_next   = cur_prv;
                    n_next     = '0;
                    state_next = S_BWD;
                end else if (n_last) begin
                    state_next = S_MOVE0;
                end else begin
                    sm_raddr = cur_nxt;
                    cur_next = cur_nxt;
                    n_next   = n_reg + SW'(1);
                end
            end
            S_BWD: begin
                if (!sr_tomb) begin
                    state_next = S_MOVE0;
                end else begin
                    sm_we    = 1'b1;
                    sm_wdata = {{TB{1'b0}}, {PB{1'b0}}, sr_ent};
                    if (n_last) begin
                        state_next = S_MOVE0;
                    end else begin
                        sm_raddr = cur_prv;
                        cur_next = cur_prv;
                        n_next   = n_reg + SW'(1);
                    end
                end
            end
            S_MOVE0: begin
                if (CW'(ent_reg) != count_m1) begin
                    em_raddr   = count_m1[EAW-1:0];
                    state_next = S_MOVE_E;
                end else begin
                    count_next = count_m1;
                    state_next = S_FINISH;
                end
            end
            S_MOVE_E: begin
                // The last entry fills the hole; its slot then points at the hole.
                em_we      = 1'b1;
                em_wdata   = {er_slot_ok, er_vtag, er_val};
                sm_raddr   = er_slot_ok;
                cur_next   = er_slot_ok;
                state_next = S_MOVE_S;
            end
            S_MOVE_S: begin
                sm_we      = 1'b1;
                sm_wdata   = {sr_tag, sr_pay, ent_reg};
                count_next = count_m1;
                state_next = S_FINISH;
            end
            S_IDX_E: begin
                rval_next  = er_val;
                rvtag_next = er_vtag;
                sm_raddr   = er_slot_ok;
                cur_next   = er_slot_ok;
                state_next = S_IDX_S;
            end
            S_IDX_S: begin
                rkey_next  = sr_pay;
                rktag_next = sr_tag;
                state_next = S_FINISH;
            end
            S_INIT, S_CLR: begin
                sm_we = 1'b1;
                if (cur_reg == SLOT_LAST) begin
                    count_next = '0;
                    state_next = (state_reg == S_INIT) ? S_IDLE : S_FINISH;
                end else begin
                    cur_next = cur_reg + SW'(1);
                end
            end
            S_FINISH: begin
                if (load_out) begin
                    state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (load_out) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= S_INIT;
            cur_reg       <= '0;
            n_reg         <= '0;
            tomb_reg      <= '0;
            have_tomb_reg <= 1'b0;
            count_reg     <= '0;
            seed_reg      <= '0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cur_reg       <= cur_next;
            n_reg         <= n_next;
            tomb_reg      <= tomb_next;
            have_tomb_reg <= have_tomb_next;
            count_reg     <= count_next;
            seed_reg      <= seed_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        ent_reg   <= ent_next;
        rstat_reg <= rstat_next;
        rkey_reg  <= rkey_next;
        rktag_reg <= rktag_next;
        rval_reg  <= rval_next;
        rvtag_reg <= rvtag_next;
        if (accept) begin
            act_reg  <= s_action;
            key_reg  <= s_key;
            ktag_reg <= s_key_type;
            val_reg  <= s_value;
            vtag_reg <= s_value_type;
            pos_reg  <= s_position;
        end
        if (load_out) begin
            ostat_reg  <= rstat_reg;
            okey_reg   <= rkey_reg;
            oktag_reg  <= rktag_reg;
            oval_reg   <= rval_reg;
            ovtag_reg  <= rvtag_reg;
            ocount_reg <= count_reg;
        end
    end

    assign m_valid          = m_valid_reg;
    assign m_status         = ostat_reg;
    assign m_out_key        = okey_reg;
    assign m_out_key_type   = oktag_reg;
    assign m_out_value      = oval_reg;
    assign m_out_value_type = ovtag_reg;
    assign m_entry_count    = ocount_reg;

endmodule

[rtl/lpht_checker.sv]
// Port-level checker for the linear probe hash table, bound to the top level.
module lpht_checker #(
    parameter int MAX_ENTRIES  = 768,
    parameter int PAYLOAD_BITS = 64,
    parameter int TYPE_BITS    = 4
) (
    input logic                             aclk,
    input logic                             aresetn,
    input logic                             s_ready,
    input logic                             m_valid,
    input logic                             m_ready,
    input lpht_pkg::status_t                m_status,
    input logic [PAYLOAD_BITS-1:0]          m_out_value,
    input logic [TYPE_BITS-1:0]             m_out_value_type,
    input logic [$clog2(MAX_ENTRIES+1)-1:0] m_entry_count
);

    localparam int CW = $clog2(MAX_ENTRIES+1);
    localparam logic [CW-1:0] ENT_MAX = CW'(MAX_ENTRIES);

    // Reset starts the slot clearing pass, so nothing is taken or shown right after it.
    a_reset_quiet: assert property (@(posedge aclk)
        !aresetn |=> !s_ready && !m_valid)
        else $error("block not quiet after reset");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> m_entry_count <= ENT_MAX)
        else $error("entry count above capacity");

    // A refused insert only happens at capacity, since a lap always finds a free slot below it.
    a_full_at_cap: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_status == lpht_pkg::ST_FULL |-> m_entry_count == ENT_MAX)
        else $error("full status below capacity");

    a_miss_nil: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == lpht_pkg::ST_NOT_FOUND || m_status == lpht_pkg::ST_RANGE)
        |-> m_out_value == '0 && m_out_value_type == '0)
        else $error("miss returned a value");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_status) && $stable(m_out_value))
        else $error("stalled result changed");

endmodule

bind linear_probe_hash_table_unit lpht_checker #(
    .MAX_ENTRIES  (MAX_ENTRIES),
    .PAYLOAD_BITS (PAYLOAD_BITS),
    .TYPE_BITS    (TYPE_BITS)
) u_lpht_checker (
    .aclk             (aclk),
    .aresetn          (aresetn),
    .s_ready          (s_ready),
    .m_valid          (m_valid),
    .m_ready          (m_ready),
    .m_status         (m_status),
    .m_out_value      (m_out_value),
    .m_out_value_type (m_out_value_type),
    .m_entry_count    (m_entry_count)
);

[bench/tb_linear_probe_hash_table_unit.sv]
// Self-checking testbench for the linear probe hash table unit.
`timescale 1ns / 100ps

module tb_linear_probe_hash_table_unit;

    localparam int MAX_ENTRIES = 768;
    localparam int CYCLE_LIMIT = 3000000;
    localparam int POOL = 64;

    typedef struct packed {
        lpht_pkg::action_t action;
        logic [63:0]       key;
        logic [3:0]        key_type;
        logic [63:0]       value;
        logic [3:0]        value_type;
        logic [9:0]        position;
    } op_t;

    typedef struct packed {
        lpht_pkg::status_t status;
        logic [63:0]       key;
        logic [3:0]        key_type;
        logic [63:0]       value;
        logic [3:0]        value_type;
        logic [9:0]        count;
    } answer_t;

    typedef struct packed {
        op_t     op;
        logic    typed;
        answer_t ans;
    } dir_row_t;

    logic              aclk = 1'b0;
    logic              aresetn = 1'b0;
    logic              cfg_wr_en = 1'b0;
    logic [31:0]       cfg_wr_data = '0;
    logic              s_valid = 1'b0;
    logic              s_ready;
    lpht_pkg::action_t s_action = lpht_pkg::ACT_GET;
    logic [63:0]       s_key = '0;
    logic [3:0]        s_key_type = '0;
    logic [63:0]       s_value = '0;
    logic [3:0]        s_value_type = '0;
    logic [9:0]        s_position = '0;
    logic              m_valid;
    logic              m_ready = 1'b0;
    lpht_pkg::status_t m_status;
    logic [63:0]       m_out_key;
    logic [3:0]        m_out_key_type;
    logic [63:0]       m_out_value;
    logic [3:0]        m_out_value_type;
    logic [9:0]        m_entry_count;

    linear_probe_hash_table_unit u_top (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cfg_wr_en        (cfg_wr_en),
        .cfg_wr_data      (cfg_wr_data),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_action         (s_action),
        .s_key            (s_key),
        .s_key_type       (s_key_type),
        .s_value          (s_value),
        .s_value_type     (s_value_type),
        .s_position       (s_position),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_out_key        (m_out_key),
        .m_out_key_type   (m_out_key_type),
        .m_out_value      (m_out_value),
        .m_out_value_type (m_out_value_type),
        .m_entry_count    (m_entry_count)
    );

    always begin
        #4 aclk = 1'b1;
        #4 aclk = 1'b0;
    end

    // Placement never shows in a result, so the map is kept as its dense entry list.
    logic [63:0] map_key   [MAX_ENTRIES];
    logic [3:0]  map_ktype [MAX_ENTRIES];
    logic [63:0] map_val   [MAX_ENTRIES];
    logic [3:0]  map_vtype [MAX_ENTRIES];
    int          map_count = 0;

    logic [63:0] pool_key  [POOL];
    logic [3:0]  pool_ktype[POOL];

    answer_t pending_answers[$];
    int      fail_count = 0;
    int      answers_seen = 0;
    int      status_seen[4] = '{0, 0, 0, 0};
    int      peak_count = 0;
    int      cycle_count = 0;
    int      burst_left = 0;

    task automatic apply_to_map(input op_t op, output answer_t ans);
        int hit;
        int last;
        hit = -1;
        ans = '{status: lpht_pkg::ST_OK, key: op.key, key_type: op.key_type, value: '0,
                value_type: '0, count: '0};
        if (op.action <= lpht_pkg::ACT_POP) begin
            for (int i = 0; i < map_count; i++) begin
                if (map_key[i] == op.key && map_ktype[i] == op.key_type) hit = i;
            end
        end
        if (op.action <= lpht_pkg::ACT_POP && op.key_type == 4'd0) begin
            ans.status = lpht_pkg::ST_NOT_FOUND;
        end else begin
            case (op.action)
                lpht_pkg::ACT_GET: begin
                    if (hit < 0) ans.status = lpht_pkg::ST_NOT_FOUND;
                    else begin
                        ans.value = map_val[hit];
                        ans.value_type = map_vtype[hit];
                    end
                end
                lpht_pkg::ACT_SET: begin
                    if (hit >= 0) begin
                        ans.value = map_val[hit];
                        ans.value_type = map_vtype[hit];
                        map_val[hit] = op.value;
                        map_vtype[hit] = op.value_type;
                    end else if (map_count >= MAX_ENTRIES) begin
                        ans.status = lpht_pkg::ST_FULL;
                    end else begin
                        map_key[map_count] = op.key;
                        map_ktype[map_count] = op.key_type;
                        map_val[map_count] = op.value;
                        map_vtype[map_count] = op.value_type;
                        map_count++;
                    end
                end
                lpht_pkg::ACT_POP: begin
                    if (hit < 0) ans.status = lpht_pkg::ST_NOT_FOUND;
                    else begin
                        ans.value = map_val[hit];
                        ans.value_type = map_vtype[hit];
                        // The last entry moves into the hole.
                        last = map_count - 1;
                        map_key[hit] = map_key[last];
                        map_ktype[hit] = map_ktype[last];
                        map_val[hit] = map_val[last];
                        map_vtype[hit] = map_vtype[last];
                        map_count = last;
                    end
                end
                lpht_pkg::ACT_INDEX: begin
                    if (op.position >= map_count) ans.status = lpht_pkg::ST_RANGE;
                    else begin
                        ans.key = map_key[op.position];
                        ans.key_type = map_ktype[op.position];
                        ans.value = map_val[op.position];
                        ans.value_type = map_vtype[op.position];
                    end
                end
                lpht_pkg::ACT_CLEAR: map_count = 0;
                default: ;
            endcase
        end
        ans.count = map_count[9:0];
        if (map_count > peak_count) peak_count = map_count;
    endtask

    // Offers one item, waits for its acceptance and records what it must answer.
    task automatic offer_item(input op_t op, input logic typed, input answer_t typed_ans);
        answer_t ans;
        int gap;
        s_valid <= 1'b1;
        s_action <= op.action;
        s_key <= op.key;
        s_key_type <= op.key_type;
        s_value <= op.value;
        s_value_type <= op.value_type;
        s_position <= op.position;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        apply_to_map(op, ans);
        pending_answers.push_back(typed ? typed_ans : ans);
        if (burst_left == 0) begin
            burst_left = $urandom_range(0, 24);
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 6);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end else begin
            burst_left--;
        end
    endtask

    task automatic drain_answers();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (pending_answers.size() != 0) @(posedge aclk);
        repeat (8) @(posedge aclk);
    endtask

    // The seed moves every start slot, so it is only changed on an empty table.
    task automatic write_seed(input logic [31:0] seed);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= seed;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        @(posedge aclk);
    endtask

    function automatic logic [63:0] rand_word();
        return {$urandom(), $urandom()};
    endfunction

    function automatic op_t random_op(input int fill_bias);
        op_t op;
        int pick;
        int sel;
        op.value = rand_word();
        op.value_type = 4'($urandom_range(0, 15));
        op.position = 10'($urandom_range(0, 3) == 0 ? $urandom_range(0, 1023)
                                                     : $urandom_range(0, map_count + 2));
        pick = $urandom_range(0, 999);
        if (pick < fill_bias) op.action = lpht_pkg::ACT_SET;
        else if (pick < 400) op.action = lpht_pkg::ACT_SET;
        else if (pick < 620) op.action = lpht_pkg::ACT_GET;
        else if (pick < 830) op.action = lpht_pkg::ACT_POP;
        else if (pick < 975) op.action = lpht_pkg::ACT_INDEX;
        else if (pick < 977) op.action = lpht_pkg::ACT_CLEAR;
        else op.action = lpht_pkg::action_t'($urandom_range(5, 7));
        sel = $urandom_range(0, 9);
        if (fill_bias > 0 && op.action == lpht_pkg::ACT_SET) sel = 9;
        if (sel < 5 && map_count > 0) begin
            pick = $urandom_range(0, map_count - 1);
            op.key = map_key[pick];
            op.key_type = map_ktype[pick];
        end else if (sel < 9) begin
            pick = $urandom_range(0, POOL - 1);
            op.key = pool_key[pick];
            op.key_type = pool_ktype[pick];
        end else begin
            op.key = rand_word();
            op.key_type = 4'($urandom_range(1, 15));
        end
        if ($urandom_range(0, 49) == 0) op.key_type = 4'd0;
        return op;
    endfunction

    task automatic random_phase(input int n_items, input int fill_bias, input int pause_at);
        for (int i = 0; i < n_items; i++) begin
            if (i == pause_at) drain_answers();
            offer_item(random_op(fill_bias), 1'b0, '0);
        end
    endtask

    always @(posedge aclk) begin
        m_ready <= ((cycle_count / 300) % 3 == 0) ? 1'b1
                 : ((cycle_count / 300) % 3 == 1) ? ($urandom_range(0, 9) < 7)
                 : (cycle_count % 5 == 0);
    end

    always @(posedge aclk) begin
        answer_t want;
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
        if (aresetn && m_valid && m_ready) begin
            if (pending_answers.size() == 0) begin
                $error("result with nothing expected");
                fail_count++;
            end else begin
                want = pending_answers.pop_front();
                answers_seen++;
                status_seen[want.status]++;
                if (m_status != want.status) begin
                    $error("status: expected %0d, got %0d", want.status, m_status);
                    fail_count++;
                end
                if (m_out_key != want.key) begin
                    $error("out_key: expected %h, got %h", want.key, m_out_key);
                    fail_count++;
                end
                if (m_out_key_type != want.key_type) begin
                    $error("out_key_type: expected %0d, got %0d", want.key_type,
                           m_out_key_type);
                    fail_count++;
                end
                if (m_out_value != want.value) begin
                    $error("out_value: expected %h, got %h", want.value, m_out_value);
                    fail_count++;
                end
                if (m_out_value_type != want.value_type) begin
                    $error("out_value_type: expected %0d, got %0d", want.value_type,
                           m_out_value_type);
                    fail_count++;
                end
                if (m_entry_count != want.count) begin
                    $error("entry_count: expected %0d, got %0d", want.count, m_entry_count);
                    fail_count++;
                end
            end
        end
    end

    localparam logic [63:0] ONES = 64'hFFFF_FFFF_FFFF_FFFF;

    dir_row_t directed_rows[] = '{
        '{'{lpht_pkg::ACT_GET,   64'd5, 4'd1,  64'd0, 4'd0, 10'd0},  1'b1,
          '{lpht_pkg::ST_NOT_FOUND, 64'd5, 4'd1, 64'd0, 4'd0, 10'd0}},
        '{'{lpht_pkg::ACT_INDEX, 64'd9, 4'd2,  64'd0, 4'd0, 10'd0},  1'b1,
          '{lpht_pkg::ST_RANGE, 64'd9, 4'd2, 64'd0, 4'd0, 10'd0}},
        '{'{lpht_pkg::ACT_POP,   64'd5, 4'd1,  64'd0, 4'd0, 10'd0},  1'b1,
          '{lpht_pkg::ST_NOT_FOUND, 64'd5, 4'd1, 64'd0, 4'd0, 10'd0}},
        '{'{lpht_pkg::ACT_SET,   ONES,  4'd15, ONES,  4'd15, 10'd0}, 1'b1,
          '{lpht_pkg::ST_OK, ONES, 4'd15, 64'd0, 4'd0, 10'd1}},
        '{'{lpht_pkg::ACT_SET,   64'd0, 4'd1,  64'd0, 4'd0, 10'd0},  1'b1,
          '{lpht_pkg::ST_OK, 64'd0, 4'd1, 64'd0, 4'd0, 10'd2}},
        '{'{lpht_pkg::ACT_GET,   ONES,  4'd15, 64'd0, 4'd0, 10'd0},  1'b0, '0},
        '{'{lpht_pkg::ACT_GET,   ONES,  4'd14, 64'd0, 4'd0, 10'd0},  1'b0, '0},
        '{'{lpht_pkg::ACT_SET,   ONES,  4'd15, 64'h1234, 4'd3, 10'd0}, 1'b0, '0},
        '{'{lpht_pkg::ACT_GET,   ONES,  4'd0,  64'd0, 4'd0, 10'd0},  1'b1,
          '{lpht_pkg::ST_NOT_FOUND, ONES, 4'd0, 64'd0, 4'd0, 10'd2}},
        '{'{lpht_pkg::ACT_SET,   64'd7, 4'd0,  ONES,  4'd9, 10'd0},  1'b1,
          '{lpht_pkg::ST_NOT_FOUND, 64'd7, 4'd0, 64'd0, 4'd0, 10'd2}},
        '{'{lpht_pkg::ACT_POP,   64'd0, 4'd0,  64'd0, 4'd0, 10'd0},  1'b1,
          '{lpht_pkg::ST_NOT_FOUND, 64'd0, 4'd0, 64'd0, 4'd0, 10'd2}},
        '{'{lpht_pkg::ACT_INDEX, 64'd0, 4'd0,  64'd0, 4'd0, 10'd0},  1'b0, '0},
        '{'{lpht_pkg::ACT_INDEX, 64'd0, 4'd0,  64'd0, 4'd0, 10'd1},  1'b0, '0},
        '{'{lpht_pkg::ACT_INDEX, 64'd3, 4'd1,  64'd0, 4'd0, 10'd767}, 1'b1,
          '{lpht_pkg::ST_RANGE, 64'd3, 4'd1, 64'd0, 4'd0, 10'd2}},
        '{'{lpht_pkg::ACT_INDEX, ONES,  4'd15, 64'd0, 4'd0, 10'd1023}, 1'b1,
          '{lpht_pkg::ST_RANGE, ONES, 4'd15, 64'd0, 4'd0, 10'd2}},
        '{'{lpht_pkg::ACT_SET,   64'h55, 4'd8, 64'hAA, 4'd8, 10'd0},  1'b0, '0},
        '{'{lpht_pkg::ACT_POP,   64'd0, 4'd1,  64'd0, 4'd0, 10'd0},  1'b0, '0},
        '{'{lpht_pkg::ACT_POP,   64'd0, 4'd1,  64'd0, 4'd0, 10'd0},  1'b0, '0},
        '{'{lpht_pkg::ACT_INDEX, 64'd0, 4'd0,  64'd0, 4'd0, 10'd0},  1'b0, '0},
        '{'{lpht_pkg::ACT_POP,   ONES,  4'd15, 64'd0, 4'd0, 10'd0},  1'b0, '0},
        '{'{3'd5,                64'd1, 4'd1,  64'd1, 4'd1, 10'd1},  1'b0, '0},
        '{'{3'd7,                ONES,  4'd15, ONES,  4'd15, 10'd1023}, 1'b0, '0},
        '{'{lpht_pkg::ACT_CLEAR, 64'd0, 4'd1,  64'd0, 4'd0, 10'd0},  1'b1,
          '{lpht_pkg::ST_OK, 64'd0, 4'd1, 64'd0, 4'd0, 10'd0}},
        '{'{lpht_pkg::ACT_GET,   64'h55, 4'd8, 64'd0, 4'd0, 10'd0},  1'b1,
          '{lpht_pkg::ST_NOT_FOUND, 64'h55, 4'd8, 64'd0, 4'd0, 10'd0}}
    };

    initial begin
        for (int i = 0; i < POOL; i++) begin
            pool_key[i] = (i < 8) ? 64'(i) : rand_word();
            pool_ktype[i] = 4'($urandom_range(1, 15));
        end
        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        write_seed(32'hFFFF_FFFF);
        foreach (directed_rows[i]) begin
            offer_item(directed_rows[i].op, directed_rows[i].typed, directed_rows[i].ans);
        end
        drain_answers();
        write_seed(32'd0);
        // Mostly fresh inserts, enough to run the table into its full state.
        random_phase(900, 980, -1);
        random_phase(300, 0, 150);
        drain_answers();
        offer_item('{lpht_pkg::ACT_CLEAR, 64'd0, 4'd1, 64'd0, 4'd0, 10'd0}, 1'b0, '0);
        drain_answers();
        write_seed($urandom());
        random_phase(300, 100, 150);
        drain_answers();
        repeat (50) @(posedge aclk);
        $display("Checked %0d results: %0d ok, %0d not found, %0d full, %0d out of range.",
                 answers_seen, status_seen[0], status_seen[1], status_seen[2],
                 status_seen[3]);
        $display("Peak occupancy %0d of %0d entries, three seed settings.", peak_count,
                 MAX_ENTRIES);
        if (fail_count == 0 && pending_answers.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end

endmodule

[filelist.f]
rtl/lpht_pkg.sv
rtl/lpht_ram.sv
rtl/lpht_hash.sv
rtl/linear_probe_hash_table_unit.sv
rtl/lpht_checker.sv
bench/tb_linear_probe_hash_table_unit.sv
